[src/local_maxima_counter_unit_assert.svh]
// ----------------------------------------------------------------------------
// local_maxima_counter_unit_assert.svh
// Assertion macros for the local maxima counter.
// ----------------------------------------------------------------------------
`ifndef LOCAL_MAXIMA_COUNTER_UNIT_ASSERT_SVH
`define LOCAL_MAXIMA_COUNTER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define LMC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define LMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/lmc_pkg.sv]
// ----------------------------------------------------------------------------
// lmc_pkg
// Shared types and constants of the local maxima counter.
// ----------------------------------------------------------------------------
package lmc_pkg;

    localparam int SAMPLE_BITS = 16;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // window tracking flags
    typedef struct packed {
        logic have_prev;
        logic cand_open;
    } t_flags;

endpackage

[src/local_maxima_counter_unit.sv]
// ----------------------------------------------------------------------------
// local_maxima_counter_unit
// Counts local maxima (plateau-aware) over windows of streamed samples.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready carry i_sample (signed 16 bit) and i_last.
// A transfer with i_last high closes the window; one result transfer on
// o_valid / i_ready then carries o_peak_count, saturating at 2^COUNT_BITS-1.
// Samples without i_last produce no result.
// A taken sample lands in the input register and is compared and counted
// from there; a window-closing sample's count then goes into the result
// register, which drives o_peak_count.
// Throughput: one sample per cycle but for the stall below; input and
// result registers decouple the sides, so samples flow while a result waits.
// A stalled result blocks the next window-closing sample, which holds in
// the input register with o_ready low until the result register frees up.
// Reset (synchronous, active low) empties both registers and clears the
// window state; the block is ready on the first cycle after reset.
// ----------------------------------------------------------------------------
module local_maxima_counter_unit #(
    parameter int COUNT_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  lmc_pkg::t_sample       i_sample,
    input  logic                   i_last,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COUNT_BITS-1:0]  o_peak_count
);

    logic                   r_in_valid;
    lmc_pkg::t_sample       r_in_sample;
    logic                   r_in_last;

    lmc_pkg::t_sample       r_prev;
    lmc_pkg::t_flags        r_flags;
    logic [COUNT_BITS-1:0]  r_count;

    logic                   r_out_valid;
    logic [COUNT_BITS-1:0]  r_out_count;

    lmc_pkg::t_flags        n_flags;
    logic [COUNT_BITS-1:0]  n_count;

    logic                   advance;

    // only a window-closing sample needs the result slot
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    lmc_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_sample (r_in_sample),
        .i_prev   (r_prev),
        .i_flags  (r_flags),
        .i_count  (r_count),
        .o_flags  (n_flags),
        .o_count  (n_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_sample <= i_sample;
            r_in_last   <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_flags <= '0;
            r_count <= '0;
        end else if (advance) begin
            if (r_in_last) begin
                r_prev  <= '0;
                r_flags <= '0;
                r_count <= '0;
            end else begin
                r_prev  <= r_in_sample;
                r_flags <= n_flags;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_out_count <= n_count;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_peak_count = r_out_count;

`include "local_maxima_counter_unit_assert.svh"

    `LMC_ASSERT_NEXT(a_result_loaded, advance && r_in_last, r_out_valid, "result missing after window end")
    `LMC_ASSERT_NEXT(a_window_cleared, advance && r_in_last, !r_flags.have_prev && (r_count == '0), "window state not cleared")
    `LMC_ASSERT_NEXT(a_count_monotonic, advance && !r_in_last, r_count >= $past(r_count), "count decreased inside window")
    `LMC_ASSERT_SAME(a_cand_needs_prev, !r_flags.have_prev, !r_flags.cand_open, "candidate open without previous sample")

endmodule

[src/lmc_step.sv]
// ----------------------------------------------------------------------------
// lmc_step
// Per-sample peak tracking: compares a sample with its predecessor and
// returns the next flags and saturating peak count.
// ----------------------------------------------------------------------------
module lmc_step #(
    parameter int COUNT_BITS = 12
) (
    input  lmc_pkg::t_sample       i_sample,
    input  lmc_pkg::t_sample       i_prev,
    input  lmc_pkg::t_flags        i_flags,
    input  logic [COUNT_BITS-1:0]  i_count,
    output lmc_pkg::t_flags        o_flags,
    output logic [COUNT_BITS-1:0]  o_count
);

    localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

    logic rise;
    logic fall;

    assign rise = i_flags.have_prev && (i_sample > i_prev);
    assign fall = i_flags.have_prev && (i_sample < i_prev);

    always_comb begin
        o_flags.have_prev = 1'b1;
        o_flags.cand_open = i_flags.cand_open;
        o_count           = i_count;
        if (rise) begin
            o_flags.cand_open = 1'b1;
        end else if (fall) begin
            o_flags.cand_open = 1'b0;
            if (i_flags.cand_open && (i_count != CountMax)) begin
                o_count = i_count + {{(COUNT_BITS-1){1'b0}}, 1'b1};
            end
        end
    end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for local_maxima_counter_unit. A directed table covers
// short windows, edge plateaus, falls and rises on the closing sample and
// extreme sample values. Random windows with mixed shapes and lengths follow.
// Every closing sample queues its expected peak count, and each result
// transfer is compared against the oldest entry in that queue.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_BITS     = 12;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 700;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_RESULT = 20;
    localparam int PAUSE_AT_ITEM  = 300;
    localparam int STEADY_FIRST   = 450;
    localparam int STEADY_LAST    = 600;
    localparam int DRAIN_CYCLES   = 8;
    localparam int NUM_ROWS       = 25;
    localparam int NO_TYPED_COUNT = -1;

    typedef logic [COUNT_BITS-1:0] t_count;
    localparam t_count COUNT_MAX = '1;

    localparam lmc_pkg::t_sample S_MIN = 16'sh8000;
    localparam lmc_pkg::t_sample S_MAX = 16'sh7fff;

    typedef enum int {SHAPE_WIDE, SHAPE_NARROW, SHAPE_EXTREME, SHAPE_WALK} t_shape;

    // count < 0: expected value comes from the predictor
    typedef struct {
        lmc_pkg::t_sample sample;
        logic             last;
        int               count;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    lmc_pkg::t_sample i_sample;
    logic             i_last;
    logic             o_valid;
    logic             i_ready;
    t_count           o_peak_count;

    local_maxima_counter_unit #(
        .COUNT_BITS(COUNT_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (i_sample),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_peak_count (o_peak_count)
    );

    t_count           peak_q[$];
    lmc_pkg::t_sample pk_prev;
    logic             pk_have;
    logic             pk_open;
    t_count           pk_run;
    int               n_errors  = 0;
    int               n_samples = 0;
    int               n_windows = 0;
    int               n_results = 0;
    int               cyc       = 0;
    bit               steady    = 1'b0;

    t_row directed [NUM_ROWS] = '{
        '{S_MAX, 1'b1, 0},
        '{S_MIN, 1'b0, NO_TYPED_COUNT}, '{S_MAX, 1'b1, 0},
        '{S_MIN, 1'b0, NO_TYPED_COUNT}, '{16'sd0, 1'b0, NO_TYPED_COUNT},
        '{S_MIN, 1'b1, 1},
        '{16'sd0, 1'b0, NO_TYPED_COUNT}, '{-16'sd1, 1'b0, NO_TYPED_COUNT},
        '{16'sd5, 1'b1, 0},
        '{16'sd0, 1'b0, NO_TYPED_COUNT}, '{16'sd7, 1'b0, NO_TYPED_COUNT},
        '{16'sd7, 1'b1, 0},
        '{16'sd1, 1'b0, NO_TYPED_COUNT}, '{16'sd9, 1'b0, NO_TYPED_COUNT},
        '{16'sd9, 1'b0, NO_TYPED_COUNT}, '{16'sd9, 1'b0, NO_TYPED_COUNT},
        '{16'sd2, 1'b0, NO_TYPED_COUNT}, '{16'sd3, 1'b0, NO_TYPED_COUNT},
        '{16'sd3, 1'b1, NO_TYPED_COUNT},
        '{16'sd0, 1'b0, NO_TYPED_COUNT}, '{16'sd5, 1'b0, NO_TYPED_COUNT},
        '{16'sd10, 1'b0, NO_TYPED_COUNT}, '{-16'sd20, 1'b0, NO_TYPED_COUNT},
        '{S_MAX, 1'b0, NO_TYPED_COUNT}, '{16'sd32766, 1'b1, NO_TYPED_COUNT}
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cyc <= cyc + 1;

    initial begin
        wait (cyc == CYCLE_LIMIT);
        $display("FAIL local_maxima_counter_unit");
        $finish;
    end

    // plateau-aware peak tracking; returns 1 when the sample closes a window
    function automatic bit track_peaks(lmc_pkg::t_sample s, logic l, output t_count cnt);
        if (pk_have) begin
            if (s > pk_prev) begin
                pk_open = 1'b1;
            end else if (s < pk_prev) begin
                if (pk_open && pk_run != COUNT_MAX) pk_run++;
                pk_open = 1'b0;
            end
        end
        pk_prev = s;
        pk_have = 1'b1;
        cnt     = pk_run;
        if (l) begin
            pk_prev = '0;
            pk_have = 1'b0;
            pk_open = 1'b0;
            pk_run  = '0;
        end
        return l;
    endfunction

    task automatic send_sample(lmc_pkg::t_sample s, logic l, int typed = NO_TYPED_COUNT);
        t_count cnt;
        while (!steady && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        i_last   <= l;
        do @(posedge i_clk); while (!o_ready);
        n_samples++;
        if (track_peaks(s, l, cnt)) begin
            peak_q.push_back(typed < 0 ? cnt : t_count'(typed));
            n_windows++;
        end
    endtask

    task automatic send_window(int len, t_shape shape);
        lmc_pkg::t_sample s;
        s = lmc_pkg::t_sample'($urandom);
        for (int k = 0; k < len; k++) begin
            case (shape)
                SHAPE_WIDE:   s = lmc_pkg::t_sample'($urandom);
                SHAPE_NARROW: s = lmc_pkg::t_sample'(int'($urandom_range(4)) - 2);
                SHAPE_EXTREME: begin
                    case ($urandom_range(3))
                        0:       s = S_MIN;
                        1:       s = S_MAX;
                        2:       s = '0;
                        default: s = '1;
                    endcase
                end
                default:      s = s + lmc_pkg::t_sample'(int'($urandom_range(4)) - 2);
            endcase
            send_sample(s, k == len - 1);
        end
    endtask

    initial begin
        int rand_start;
        int done;
        int pick;
        int len;
        bit paused;
        paused   = 1'b0;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_sample = '0;
        i_last   = 1'b0;
        pk_prev  = '0;
        pk_have  = 1'b0;
        pk_open  = 1'b0;
        pk_run   = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[r])
            send_sample(directed[r].sample, directed[r].last, directed[r].count);

        rand_start = n_samples;
        while (n_samples - rand_start < RANDOM_ITEMS) begin
            done   = n_samples - rand_start;
            steady = (done >= STEADY_FIRST && done < STEADY_LAST);
            if (!paused && done >= PAUSE_AT_ITEM) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (peak_q.size() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(99);
            if (pick < 10)
                len = $urandom_range(1, 2);
            else if (pick < 75)
                len = $urandom_range(3, 12);
            else
                len = $urandom_range(13, 40);
            send_window(len, t_shape'($urandom_range(3)));
        end
        steady = 1'b0;
        i_valid <= 1'b0;

        while (peak_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d samples over %0d windows, %0d counts returned;",
                 n_samples, n_windows, n_results);
        $display("short windows, plateaus, closing rises and falls and back-pressure included.");
        if (n_errors == 0)
            $display("PASS local_maxima_counter_unit");
        else
            $display("FAIL local_maxima_counter_unit");
        $finish;
    end

    // result side: check each transfer, random back-pressure, one long hold-off
    initial begin
        int     hold_left;
        bit     held;
        t_count want;
        hold_left = 0;
        held      = 1'b0;
        i_ready   = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                n_results++;
                if (peak_q.size() == 0) begin
                    $error("unexpected transfer: peak_count actual %0d", o_peak_count);
                    n_errors++;
                end else begin
                    want = peak_q.pop_front();
                    if (o_peak_count !== want) begin
                        $error("peak_count mismatch: expected %0d, actual %0d",
                               want, o_peak_count);
                        n_errors++;
                    end
                end
                if (!held && n_results == HOLD_AT_RESULT) begin
                    held      = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= steady || $urandom_range(99) >= 20;
            end
        end
    end

endmodule
